@@ rtl/arpp_pkg.sv @@
// shared types and constants for the audio ring pwm passthrough block
// no dependencies
`timescale 1ns / 1ps

package arpp_pkg;

  localparam int RING_DEPTH_DEF = 2048;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;
  localparam int FULL_SCALE     = 32768;
  localparam int FS_SHIFT       = $clog2(FULL_SCALE);
  localparam int PWM_W          = 12;
  localparam int DIV_W          = 3;
  localparam int SAMPLE_W       = 16;
  localparam int PROD_W         = SAMPLE_W + PWM_W;

  localparam logic [PWM_W-1:0] PWM_MAX_RESET = 12'd840;
  localparam logic [DIV_W-1:0] TICK_DIV_RESET = 3'd6;

  typedef enum logic {
    REG_PWM_PERIOD_MAX = 1'b0,
    REG_TICK_DIVIDE    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       mic_active;
    logic                       last_in_block;
  } item_t;

  typedef struct packed {
    logic                       duty_valid;
    logic [PWM_W-1:0]           duty;
    logic                       block_done;
    logic [SAMPLE_W-1:0]        block_peak;
    logic signed [SAMPLE_W-1:0] block_first_sample;
  } result_t;

  // classified work handed from front to back
  typedef struct packed {
    logic                       pop;
    logic                       block_done;
    logic [SAMPLE_W-1:0]        block_peak;
    logic signed [SAMPLE_W-1:0] block_first_sample;
  } job_t;

  typedef struct packed {
    job_t                       job;
    logic signed [SAMPLE_W-1:0] sample;
  } mid_word_t;

endpackage

@@ rtl/arpp_fifo.sv @@
// small register queue used between front, back and the result port
// depends on nothing
`timescale 1ns / 1ps

module arpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/arpp_front.sv @@
// front end: tick divider, ring store with pointers, block peak meter
// depends on arpp_pkg
`timescale 1ns / 1ps

module arpp_front
  import arpp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  item_t            item,
  input  logic [DIV_W-1:0] tick_divide,
  output logic             fetch_valid,
  output mid_word_t        fetch_word
);

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;

  logic [RING_AW-1:0]         wr_ptr, wr_ptr_next;
  logic [RING_AW-1:0]         rd_ptr, rd_ptr_next;
  logic [DIV_W-1:0]           tick_count, tick_count_next;
  logic [SAMPLE_W-1:0]        running_peak, running_peak_next;
  logic                       block_open, block_open_next;
  logic signed [SAMPLE_W-1:0] first_raw, first_raw_next;
  job_t                       fetch_job, fetch_job_next;

  logic [DIV_W:0]             cnt;
  logic                       due;
  logic                       do_pop;
  logic                       do_write;
  logic signed [SAMPLE_W-1:0] gated;
  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        peak_base;
  logic [SAMPLE_W-1:0]        peak_new;

  assign cnt      = {1'b0, tick_count} + 1'b1;
  assign due      = (cnt >= {1'b0, tick_divide});
  assign do_pop   = accept && !item.func && due && (rd_ptr != wr_ptr);
  assign do_write = accept && item.func;
  assign gated    = item.mic_active ? item.sample_value : '0;
  assign mag      = gated[SAMPLE_W-1] ? (~gated + 1'b1) : gated;
  assign peak_base = block_open ? running_peak : '0;
  assign peak_new  = (mag > peak_base) ? mag : peak_base;

  always_comb begin
    wr_ptr_next       = wr_ptr;
    rd_ptr_next       = rd_ptr;
    tick_count_next   = tick_count;
    running_peak_next = running_peak;
    block_open_next   = block_open;
    first_raw_next    = first_raw;
    fetch_job_next    = '0;
    if (accept) begin
      if (!item.func) begin
        tick_count_next = due ? '0 : cnt[DIV_W-1:0];
        if (do_pop) begin
          rd_ptr_next        = (rd_ptr == RING_LAST) ? '0 : rd_ptr + 1'b1;
          fetch_job_next.pop = 1'b1;
        end
      end else begin
        wr_ptr_next = (wr_ptr == RING_LAST) ? '0 : wr_ptr + 1'b1;
        if (!block_open) begin
          first_raw_next = item.sample_value;
        end
        if (item.last_in_block) begin
          fetch_job_next.block_done         = 1'b1;
          fetch_job_next.block_peak         = peak_new;
          fetch_job_next.block_first_sample = block_open ? first_raw : item.sample_value;
          block_open_next                   = 1'b0;
          running_peak_next                 = '0;
        end else begin
          block_open_next   = 1'b1;
          running_peak_next = peak_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      tick_count   <= '0;
      running_peak <= '0;
      block_open   <= 1'b0;
      first_raw    <= '0;
      fetch_valid  <= 1'b0;
    end else begin
      wr_ptr       <= wr_ptr_next;
      rd_ptr       <= rd_ptr_next;
      tick_count   <= tick_count_next;
      running_peak <= running_peak_next;
      block_open   <= block_open_next;
      first_raw    <= first_raw_next;
      fetch_valid  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fetch_job <= fetch_job_next;
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      ring[wr_ptr] <= gated;
    end
    if (do_pop) begin
      rdata <= ring[rd_ptr];
    end
  end

  assign fetch_word.job    = fetch_job;
  assign fetch_word.sample = rdata;

endmodule

@@ rtl/arpp_back.sv @@
// back end: sample to pwm duty scaling with clamp, result assembly
// depends on arpp_pkg
`timescale 1ns / 1ps

module arpp_back
  import arpp_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mid_valid,
  input  mid_word_t                      mid_word,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  input  logic [PWM_W-1:0]               pwm_period_max,
  output logic                           res_push,
  output result_t                        res_word
);

  localparam int CW = $clog2(OUT_DEPTH+1);

  logic [PWM_W-2:0]         half;
  logic                     s1_valid;
  job_t                     s1_job;
  logic signed [PROD_W-1:0] s1_prod;
  logic [CW:0]              in_flight;

  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] q_full;
  logic [PWM_W+1:0]         d;
  logic [PWM_W-1:0]         duty;

  assign half      = pwm_period_max[PWM_W-1:1];
  assign in_flight = {1'b0, out_count} + (CW+1)'(s1_valid);
  assign mid_pop   = mid_valid && (in_flight < (CW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_job  <= mid_word.job;
      s1_prod <= mid_word.sample * $signed({1'b0, half});
    end
  end

  // divide by full scale with truncation toward zero
  assign biased = s1_prod + (s1_prod[PROD_W-1] ? PROD_W'(FULL_SCALE - 1) : '0);
  assign q_full = biased >>> FS_SHIFT;
  assign d      = (PWM_W+2)'(q_full) + (PWM_W+2)'(half);

  always_comb begin
    if (d[PWM_W+1]) begin
      duty = '0;
    end else if (d > {2'b00, pwm_period_max}) begin
      duty = pwm_period_max;
    end else begin
      duty = d[PWM_W-1:0];
    end
  end

  assign res_push                    = s1_valid;
  assign res_word.duty_valid         = s1_job.pop;
  assign res_word.duty               = s1_job.pop ? duty : '0;
  assign res_word.block_done         = s1_job.block_done;
  assign res_word.block_peak         = s1_job.block_peak;
  assign res_word.block_first_sample = s1_job.block_first_sample;

endmodule

@@ rtl/audio_ring_pwm_passthrough.sv @@
// top level of the audio ring pwm passthrough block
// depends on arpp_pkg, arpp_front, arpp_fifo, arpp_back
`timescale 1ns / 1ps

// Takes one word (timer tick or microphone sample) per clock while full is
// low and returns exactly one result word for each, in order. Each word
// passes through the front (ring access and classification, with the ring
// read registered), the queue between front and back and the registered
// duty multiply; the output queue then holds its result until popped.
// Sustained rate is one word per cycle while results are popped; full rises
// when the four-entry queue between front and back has no room. The ring
// store needs no clearing after reset; a read of an entry never written
// returns arbitrary data. Configuration writes take effect the next cycle
// and should be made only while the block is idle.

module audio_ring_pwm_passthrough
  import arpp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  item_t            item,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             wr_en,
  input  reg_index_t       wr_index,
  input  logic [PWM_W-1:0] wr_data
);

  localparam int MCW = $clog2(MID_DEPTH+1);
  localparam int OCW = $clog2(OUT_DEPTH+1);

  logic [PWM_W-1:0] pwm_period_max;
  logic [DIV_W-1:0] tick_divide;

  logic             accept;
  logic             fetch_valid;
  mid_word_t        fetch_word;
  logic             mid_empty;
  logic             mid_pop;
  mid_word_t        mid_word;
  logic [MCW-1:0]   mid_count;
  logic [MCW:0]     mid_used;
  logic             res_push;
  result_t          res_word;
  logic [OCW-1:0]   out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period_max <= PWM_MAX_RESET;
      tick_divide    <= TICK_DIV_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PWM_PERIOD_MAX: pwm_period_max <= wr_data;
        REG_TICK_DIVIDE:    tick_divide    <= wr_data[DIV_W-1:0];
        default:            ;
      endcase
    end
  end

  // room is reserved for the word still in the fetch stage
  assign mid_used = {1'b0, mid_count} + (MCW+1)'(fetch_valid);
  assign full     = (mid_used >= (MCW+1)'(MID_DEPTH));
  assign accept   = push && !full;

  arpp_front #(
    .RING_DEPTH(RING_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .tick_divide(tick_divide),
    .fetch_valid(fetch_valid),
    .fetch_word (fetch_word)
  );

  arpp_fifo #(
    .WIDTH($bits(mid_word_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (fetch_valid),
    .din  (fetch_word),
    .pop  (mid_pop),
    .dout (mid_word),
    .empty(mid_empty),
    .count(mid_count)
  );

  arpp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .mid_valid     (!mid_empty),
    .mid_word      (mid_word),
    .mid_pop       (mid_pop),
    .out_count     (out_count),
    .pwm_period_max(pwm_period_max),
    .res_push      (res_push),
    .res_word      (res_word)
  );

  arpp_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_word),
    .pop  (pop),
    .dout (result),
    .empty(empty),
    .count(out_count)
  );

`ifndef NO_ASSERTIONS
  a_fetch_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> fetch_valid)
    else $error("accepted word did not reach the fetch stage");

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fetch_valid |-> (mid_count < MCW'(MID_DEPTH)))
    else $error("front to back queue overflow");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_result_one_kind: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !(res_word.duty_valid && res_word.block_done))
    else $error("result carries both a duty and a block report");
`endif

endmodule
